@@ design/ustc_pkg.sv @@
`default_nettype none

package ustc_pkg;

	// field and datapath widths
	localparam int SecsW = 33;
	localparam int RemW  = 17;
	localparam int DaysW = 17;
	localparam int ZoneW = 5;
	localparam int InW   = 32;
	localparam int OutW  = 40;

	// configuration register indexes
	localparam logic REG_ZONE_ENABLE = 1'b0;
	localparam logic REG_ZONE_HOURS  = 1'b1;

	// datapath operations
	localparam logic [3:0] OP_NONE     = 4'd0;
	localparam logic [3:0] OP_LOAD     = 4'd1;
	localparam logic [3:0] OP_DAY      = 4'd2;
	localparam logic [3:0] OP_DAY_REM  = 4'd3;
	localparam logic [3:0] OP_HOUR     = 4'd4;
	localparam logic [3:0] OP_HOUR_REM = 4'd5;
	localparam logic [3:0] OP_MIN      = 4'd6;
	localparam logic [3:0] OP_MIN_REM  = 4'd7;
	localparam logic [3:0] OP_YEAR     = 4'd8;
	localparam logic [3:0] OP_MONTH    = 4'd9;
	localparam logic [3:0] OP_PUBLISH  = 4'd10;

	localparam logic [RemW-1:0] SecsPerDay  = 17'd86400;
	localparam logic [RemW-1:0] SecsPerHour = 17'd3600;
	localparam logic [RemW-1:0] SecsPerMin  = 17'd60;
	localparam logic [RemW-1:0] DaysPerWeek = 17'd7;

	// rounded-up reciprocals, exact over the operand ranges used
	localparam logic [26:0] DayRecip  = 27'd101806633; // 2^36 / 675, after a shift by 7
	localparam logic [17:0] WeekRecip = 18'd149797;    // 2^20 / 7
	localparam logic [17:0] HourRecip = 18'd149131;    // 2^29 / 3600
	localparam logic [12:0] MinRecip  = 13'd4370;      // 2^18 / 60

	typedef struct packed {
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic year_done;
		logic month_done;
	} stat_t;

	// years 1970..2225: multiples of four except the two non-leap centuries
	function automatic logic is_leap(input logic [7:0] off);
		logic [11:0] y;
		y = 12'd1970 + {4'd0, off};
		return (y[1:0] == 2'd0) && (y != 12'd2100) && (y != 12'd2200);
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		case (m)
			4'd2:                      n = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   n = 5'd30;
			default:                   n = 5'd31;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

@@ design/ustc_ctrl.sv @@
`default_nettype none

module ustc_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	input  wire ustc_pkg::stat_t stat,
	output ustc_pkg::cmd_t      cmd
);

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_DAY      = 4'd1;
	localparam logic [3:0] ST_DAY_REM  = 4'd2;
	localparam logic [3:0] ST_HOUR     = 4'd3;
	localparam logic [3:0] ST_HOUR_REM = 4'd4;
	localparam logic [3:0] ST_MIN      = 4'd5;
	localparam logic [3:0] ST_MIN_REM  = 4'd6;
	localparam logic [3:0] ST_YEARS    = 4'd7;
	localparam logic [3:0] ST_MONTHS   = 4'd8;
	localparam logic [3:0] ST_DONE     = 4'd9;

	logic [3:0] state_q, state_d;
	logic       m_tvalid_q;
	logic       publish;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign publish  = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// next state and command
	always_comb begin
		state_d = state_q;
		cmd.op  = ustc_pkg::OP_NONE;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = ustc_pkg::OP_LOAD;
					state_d = ST_DAY;
				end
			end
			ST_DAY: begin
				cmd.op  = ustc_pkg::OP_DAY;
				state_d = ST_DAY_REM;
			end
			ST_DAY_REM: begin
				cmd.op  = ustc_pkg::OP_DAY_REM;
				state_d = ST_HOUR;
			end
			ST_HOUR: begin
				cmd.op  = ustc_pkg::OP_HOUR;
				state_d = ST_HOUR_REM;
			end
			ST_HOUR_REM: begin
				cmd.op  = ustc_pkg::OP_HOUR_REM;
				state_d = ST_MIN;
			end
			ST_MIN: begin
				cmd.op  = ustc_pkg::OP_MIN;
				state_d = ST_MIN_REM;
			end
			ST_MIN_REM: begin
				cmd.op  = ustc_pkg::OP_MIN_REM;
				state_d = ST_YEARS;
			end
			ST_YEARS: begin
				cmd.op = ustc_pkg::OP_YEAR;
				if (stat.year_done) begin
					state_d = ST_MONTHS;
				end
			end
			ST_MONTHS: begin
				cmd.op = ustc_pkg::OP_MONTH;
				if (stat.month_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (publish) begin
					cmd.op  = ustc_pkg::OP_PUBLISH;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (publish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/ustc_dp.sv @@
`default_nettype none

module ustc_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [ustc_pkg::ZoneW-1:0]  cfg_data,
	input  wire logic [ustc_pkg::InW-1:0]    in_secs,
	input  wire ustc_pkg::cmd_t              cmd,
	output ustc_pkg::stat_t                  stat,
	output logic [ustc_pkg::OutW-1:0]        out_data
);

	localparam int SW = ustc_pkg::SecsW;
	localparam int RW = ustc_pkg::RemW;
	localparam int DW = ustc_pkg::DaysW;

	logic                          zone_en_q;
	logic [ustc_pkg::ZoneW-1:0]    zone_q;
	logic [SW-1:0]                 num_q;
	logic [RW-1:0]                 r_q;
	logic [DW-1:0]                 days_q;
	logic [14:0]                   wq_q;
	logic [4:0]                    hour_q;
	logic [5:0]                    minute_q;
	logic [5:0]                    second_q;
	logic [2:0]                    weekday_q;
	logic [7:0]                    year_q;
	logic [3:0]                    month_q;
	logic [ustc_pkg::OutW-1:0]     out_q;

	logic signed [4:0]  zone_adj;
	logic signed [17:0] shift;
	logic signed [34:0] shifted;
	logic [SW-1:0]      start_secs;
	logic [52:0]        day_prod;
	logic [SW-1:0]      day_base;
	logic [SW-1:0]      day_rem;
	logic [DW-1:0]      wk_in;
	logic [34:0]        wk_prod;
	logic [DW-1:0]      wk_base;
	logic [DW-1:0]      wk_diff;
	logic [34:0]        hr_prod;
	logic [RW-1:0]      hr_base;
	logic [24:0]        mn_prod;
	logic [RW-1:0]      mn_base;
	logic [RW-1:0]      sc_diff;
	logic [8:0]         ylen;
	logic [4:0]         mlen;
	logic               yr_done;
	logic               mo_done;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_en_q <= 1'b0;
			zone_q    <= 5'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				ustc_pkg::REG_ZONE_ENABLE: zone_en_q <= cfg_data[0];
				default:                   zone_q    <= cfg_data;
			endcase
		end
	end

	// zone shift, negative zones raised by one, clamped at zero
	always_comb begin
		zone_adj = $signed(zone_q);
		if (zone_adj < 0) begin
			zone_adj = zone_adj + 5'sd1;
		end
		shift   = 18'(zone_adj * 18'sd3600);
		shifted = $signed({3'b000, in_secs});
		if (zone_en_q) begin
			shifted = shifted + 35'(shift);
		end
		start_secs = shifted[34] ? '0 : shifted[SW-1:0];
	end

	// days: seconds / 128 times the reciprocal of 675
	assign day_prod = {27'd0, num_q[SW-1:7]} * {26'd0, ustc_pkg::DayRecip};
	assign day_base = {16'd0, days_q} * {16'd0, ustc_pkg::SecsPerDay};
	assign day_rem  = num_q - day_base;

	// weekday from days plus four, modulo seven
	assign wk_in   = days_q + 17'd4;
	assign wk_prod = {18'd0, wk_in} * {17'd0, ustc_pkg::WeekRecip};
	assign wk_base = {2'd0, wq_q} * ustc_pkg::DaysPerWeek;
	assign wk_diff = wk_in - wk_base;

	// hour, minute and second from the seconds of the day
	assign hr_prod = {18'd0, r_q} * {17'd0, ustc_pkg::HourRecip};
	assign hr_base = {12'd0, hour_q} * ustc_pkg::SecsPerHour;
	assign mn_prod = {13'd0, r_q[11:0]} * {12'd0, ustc_pkg::MinRecip};
	assign mn_base = {11'd0, minute_q} * ustc_pkg::SecsPerMin;
	assign sc_diff = r_q - mn_base;

	// year and month tests
	assign ylen    = ustc_pkg::is_leap(year_q) ? 9'd366 : 9'd365;
	assign mlen    = ustc_pkg::month_len(month_q, ustc_pkg::is_leap(year_q));
	assign yr_done = days_q < {8'd0, ylen};
	assign mo_done = (days_q < {12'd0, mlen}) || (month_q >= 4'd12);
	assign stat    = '{year_done: yr_done, month_done: mo_done};

	always_ff @(posedge clk) begin
		case (cmd.op)
			ustc_pkg::OP_LOAD: begin
				num_q   <= start_secs;
				year_q  <= 8'd0;
				month_q <= 4'd1;
			end
			ustc_pkg::OP_DAY: begin
				days_q <= day_prod[52:36];
			end
			ustc_pkg::OP_DAY_REM: begin
				r_q  <= day_rem[RW-1:0];
				wq_q <= wk_prod[34:20];
			end
			ustc_pkg::OP_HOUR: begin
				hour_q    <= hr_prod[33:29];
				weekday_q <= wk_diff[2:0];
			end
			ustc_pkg::OP_HOUR_REM: begin
				r_q <= r_q - hr_base;
			end
			ustc_pkg::OP_MIN: begin
				minute_q <= mn_prod[23:18];
			end
			ustc_pkg::OP_MIN_REM: begin
				second_q <= sc_diff[5:0];
			end
			ustc_pkg::OP_YEAR: begin
				if (!yr_done) begin
					days_q <= days_q - {8'd0, ylen};
					year_q <= year_q + 8'd1;
				end
			end
			ustc_pkg::OP_MONTH: begin
				if (!mo_done) begin
					days_q  <= days_q - {12'd0, mlen};
					month_q <= month_q + 4'd1;
				end
			end
			ustc_pkg::OP_PUBLISH: begin
				out_q <= {3'b000, weekday_q, second_q, minute_q, hour_q,
					days_q[4:0] + 5'd1, month_q, year_q};
			end
			default: begin
			end
		endcase
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

@@ design/unix_seconds_to_calendar.sv @@
// channel  | dir | handshake         | payload
// s        | in  | s_tvalid/s_tready | s_tdata: unix_seconds
// m        | out | m_tvalid/m_tready | m_tdata: year_offset .. weekday
// cfg      | in  | cfg_we            | cfg_index, cfg_data
//
// one request at a time: day, hour and minute multiply and remainder steps,
// then a walk over the years (up to 136) and over the months (up to 11),
// then a publish step that waits until the output register is free;
// the result sits in an output register, so a new request is taken while
// the previous result waits for m_tready; the next result waits behind it
// reset: zone shift off, zone number 8, no result pending

`default_nettype none

module unix_seconds_to_calendar (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] unix_seconds
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] year_offset, [11:8] month, [16:12] day, [21:17] hour,
	// [27:22] minute, [33:28] second, [36:34] weekday, [39:37] zero
	output logic [39:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data
);

	ustc_pkg::cmd_t  cmd;
	ustc_pkg::stat_t stat;

	ustc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ustc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_secs   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

@@ design/ustc_checker.sv @@
`default_nettype none

module ustc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata
);

	// one request in flight: no new request right after one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// a fresh result only appears after a busy cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result without conversion");

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// result fields in calendar range
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11:8] != 4'd0) && (m_tdata[11:8] <= 4'd12)
			&& (m_tdata[16:12] != 5'd0) && (m_tdata[21:17] <= 5'd23)
			&& (m_tdata[27:22] <= 6'd59) && (m_tdata[33:28] <= 6'd59)
			&& (m_tdata[36:34] <= 3'd6) && (m_tdata[39:37] == 3'd0))
		else $error("result field out of range");

endmodule

bind unix_seconds_to_calendar ustc_checker u_ustc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
